[hw/rtl/fbe_pkg.sv]
// fbe_pkg: shared constants and types for the feedback echo delay
// no dependencies; used by feedback_echo_delay_top
`default_nettype none

package fbe_pkg;

  localparam int unsigned MAX_DELAY_DEF   = 65536;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  localparam int unsigned IO_BITS    = 16;
  localparam int unsigned DELAY_BITS = 16;
  localparam int unsigned GAIN_BITS  = 15;
  localparam int unsigned CFG_BITS   = 16;

  localparam logic [DELAY_BITS-1:0] DELAY_RST    = 16'd24000;
  localparam logic [GAIN_BITS-1:0]  DRY_GAIN_RST = 15'd16384;
  localparam logic [GAIN_BITS-1:0]  WET_GAIN_RST = 15'd16384;
  localparam logic [GAIN_BITS-1:0]  FB_GAIN_RST  = 15'd13107;

  typedef enum logic [1:0] {
    REG_DELAY    = 2'd0,
    REG_DRY_GAIN = 2'd1,
    REG_WET_GAIN = 2'd2,
    REG_FB_GAIN  = 2'd3
  } cfg_reg_e;

endpackage

`default_nettype wire

[hw/rtl/fbe_ram.sv]
// fbe_ram: generic single-port ram with registered read
// no dependencies; instantiated by feedback_echo_delay_top
`default_nettype none

module fbe_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (en_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/feedback_echo_delay_top.sv]
// feedback_echo_delay_top: echo effect, feedback delay line in a single-port ram
// depends on fbe_pkg and fbe_ram
//
// usage:
//   input channel in_valid_i / in_stall_o / sample_in_i carries one signed
//   16-bit sample per word; output channel out_valid_o / out_stall_i /
//   sample_out_o returns exactly one echo sample per input word.
//   configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 delay, 1 dry gain, 2 wet gain, 3 feedback gain); the user must
//   assert it only while idle, the block does not enforce this. a delay
//   write restarts the fill phase: the next delay words give zero.
// sequence:
//   the single ram port reads the delayed sample, then writes the fed-back
//   sample; the input stalls until that write, and output valid is registered at it.
// reset:
//   control and config registers return to defaults, the ram is not
//   cleared; the fill phase guarantees no unwritten entry reaches the output.
// stall:
//   a held output word blocks the write cycle; the input then stalls while
//   the word in flight waits, and nothing is lost.
`default_nettype none

module feedback_echo_delay_top #(
  parameter int unsigned MAX_DELAY   = fbe_pkg::MAX_DELAY_DEF,
  parameter int unsigned SAMPLE_BITS = fbe_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [1:0]                         cfg_idx_i,
  input  wire logic [fbe_pkg::CFG_BITS-1:0]       cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [fbe_pkg::IO_BITS-1:0] sample_in_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [fbe_pkg::IO_BITS-1:0]      sample_out_o
);

  localparam int unsigned SW   = SAMPLE_BITS;
  localparam int unsigned LW   = SW + 17;
  localparam int unsigned AW   = $clog2(MAX_DELAY);
  localparam int unsigned DW   = fbe_pkg::DELAY_BITS;
  localparam int unsigned GW   = fbe_pkg::GAIN_BITS;
  localparam int unsigned RW   = ((AW > DW) ? AW : DW) + 1;
  localparam int unsigned DMAX = (MAX_DELAY - 1 < 65535) ? MAX_DELAY - 1 : 65535;

  localparam logic signed [LW-1:0] SMAX = signed'({{(LW-SW+1){1'b0}}, {(SW-1){1'b1}}});
  localparam logic signed [LW-1:0] SMIN = ~SMAX;
  localparam logic [AW-1:0]        LAST_POS = AW'(MAX_DELAY - 1);

  // configuration
  logic [DW-1:0] delay_q;
  logic [GW-1:0] dry_q, wet_q, fb_q;

  // control
  logic [AW-1:0] wp_q, wp_d;
  logic [DW-1:0] fill_q, fill_d;
  logic          busy_q;
  logic          out_valid_q;

  // second stage payload
  logic          fill_b_q;
  logic [SW-1:0] x_b_q;
  logic [AW-1:0] wp_b_q;
  logic signed [fbe_pkg::IO_BITS-1:0] sample_out_q;

  logic          accept;
  logic          b_done;
  logic [DW-1:0] d_eff;
  logic          in_fill;
  logic [RW-1:0] rdiff, rsum;
  logic [AW-1:0] rp;

  logic signed [LW-1:0] x_in_w, x_sat_w;
  logic [SW-1:0]        dl;
  logic signed [LW-1:0] x_w, dl_w;
  logic signed [SW+15:0] p_dry, p_wet, p_fb;
  logic signed [LW-1:0] q_dry, q_wet, q_fb;
  logic signed [LW-1:0] y_sum, wr_sum, y_sat, wr_sat;
  logic [SW-1:0]        wr_val;
  logic signed [fbe_pkg::IO_BITS-1:0] y_val;

  logic          ram_en;
  logic [AW-1:0] ram_addr;

  assign accept = in_valid_i && !busy_q;
  assign b_done = busy_q && (!out_valid_q || !out_stall_i);

  // effective delay and read pointer
  always_comb begin
    if (delay_q == '0) begin
      d_eff = DW'(1);
    end else if (delay_q > DW'(DMAX)) begin
      d_eff = DW'(DMAX);
    end else begin
      d_eff = delay_q;
    end
    in_fill = fill_q < d_eff;
    rdiff   = RW'(wp_q) - RW'(d_eff);
    rsum    = rdiff[RW-1] ? rdiff + RW'(MAX_DELAY) : rdiff;
    rp      = rsum[AW-1:0];
    wp_d    = (wp_q == LAST_POS) ? '0 : wp_q + AW'(1);
    fill_d  = in_fill ? fill_q + DW'(1) : fill_q;
  end

  // input saturation to the sample width
  always_comb begin
    x_in_w = $signed({{(LW-fbe_pkg::IO_BITS){sample_in_i[fbe_pkg::IO_BITS-1]}}, sample_in_i});
    if (x_in_w > SMAX) begin
      x_sat_w = SMAX;
    end else if (x_in_w < SMIN) begin
      x_sat_w = SMIN;
    end else begin
      x_sat_w = x_in_w;
    end
  end

  // mix and feedback datapath
  always_comb begin
    x_w    = $signed({{17{x_b_q[SW-1]}}, x_b_q});
    dl_w   = $signed({{17{dl[SW-1]}}, dl});
    p_dry  = $signed({1'b0, dry_q}) * $signed(x_b_q);
    p_wet  = $signed({1'b0, wet_q}) * $signed(dl);
    p_fb   = $signed({1'b0, fb_q}) * $signed(dl);
    q_dry  = $signed({p_dry[SW+15], p_dry}) >>> 15;
    q_wet  = $signed({p_wet[SW+15], p_wet}) >>> 15;
    q_fb   = $signed({p_fb[SW+15], p_fb}) >>> 15;
    y_sum  = q_dry + q_wet;
    wr_sum = x_w + q_fb;
    if (y_sum > SMAX) begin
      y_sat = SMAX;
    end else if (y_sum < SMIN) begin
      y_sat = SMIN;
    end else begin
      y_sat = y_sum;
    end
    if (wr_sum > SMAX) begin
      wr_sat = SMAX;
    end else if (wr_sum < SMIN) begin
      wr_sat = SMIN;
    end else begin
      wr_sat = wr_sum;
    end
    if (fill_b_q) begin
      y_val  = '0;
      wr_val = x_b_q;
    end else begin
      y_val  = y_sat[fbe_pkg::IO_BITS-1:0];
      wr_val = wr_sat[SW-1:0];
    end
  end

  assign ram_en   = accept || b_done;
  assign ram_addr = busy_q ? wp_b_q : rp;

  fbe_ram #(
    .WIDTH(SW),
    .DEPTH(MAX_DELAY)
  ) u_line (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (b_done),
    .addr_i (ram_addr),
    .wdata_i(wr_val),
    .rdata_o(dl)
  );

  // control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q     <= fbe_pkg::DELAY_RST;
      dry_q       <= fbe_pkg::DRY_GAIN_RST;
      wet_q       <= fbe_pkg::WET_GAIN_RST;
      fb_q        <= fbe_pkg::FB_GAIN_RST;
      wp_q        <= '0;
      fill_q      <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        wp_q   <= wp_d;
        fill_q <= fill_d;
      end
      if (cfg_we_i) begin
        unique case (fbe_pkg::cfg_reg_e'(cfg_idx_i))
          fbe_pkg::REG_DELAY: begin
            delay_q <= cfg_data_i[DW-1:0];
            fill_q  <= '0;
          end
          fbe_pkg::REG_DRY_GAIN: dry_q <= cfg_data_i[GW-1:0];
          fbe_pkg::REG_WET_GAIN: wet_q <= cfg_data_i[GW-1:0];
          fbe_pkg::REG_FB_GAIN:  fb_q  <= cfg_data_i[GW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        busy_q <= 1'b1;
      end else if (b_done) begin
        busy_q <= 1'b0;
      end
      if (b_done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fill_b_q <= in_fill;
      x_b_q    <= x_sat_w[SW-1:0];
      wp_b_q   <= wp_q;
    end
    if (b_done) begin
      sample_out_q <= y_val;
    end
  end

  assign in_stall_o   = busy_q;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;

endmodule

`default_nettype wire
